>>> design/afte_pkg.sv
// ----------------------------------------------------------------------------
// afte_pkg: shared types and codes of the aging fifo
// Field widths, command and result codes, and the entry record that moves
// through the row of storage cells.
// ----------------------------------------------------------------------------
package afte_pkg;

    localparam int ID_W    = 16;
    localparam int LIFE_W  = 10;
    localparam int DROP_W  = 6;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int OCC_W   = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PUSHED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POPPED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
    } entry_t;

endpackage

>>> design/afte_req_if.sv
// ----------------------------------------------------------------------------
// afte_req_if: command channel
// Valid/ready channel carrying one command with its push and scan operands.
// ----------------------------------------------------------------------------
interface afte_req_if import afte_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   entry_id;
    logic [LIFE_W-1:0] entry_life;
    logic [LIFE_W-1:0] alert_level;

    modport source (output valid, output cmd, output entry_id, output entry_life,
                    output alert_level, input ready);
    modport sink   (input valid, input cmd, input entry_id, input entry_life,
                    input alert_level, output ready);

endinterface

>>> design/afte_rsp_if.sv
// ----------------------------------------------------------------------------
// afte_rsp_if: result channel
// Valid/ready channel carrying one result record per transfer.
// ----------------------------------------------------------------------------
interface afte_rsp_if import afte_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_id;
    logic [LIFE_W-1:0] out_life;
    logic [OCC_W-1:0]  occupancy;
    logic              last;

    modport source (output valid, output kind, output out_id, output out_life,
                    output occupancy, output last, input ready);
    modport sink   (input valid, input kind, input out_id, input out_life,
                    input occupancy, input last, output ready);

endinterface

>>> design/aging_fifo_with_threshold_expiry_unit.sv
// ----------------------------------------------------------------------------
// aging_fifo_with_threshold_expiry_unit: bounded fifo with life expiry
// Queue of id/life entries held in a row of shifting cells.
//
// Channels: req carries a command (push, pop, scan) with its operands, rsp
// carries result records; both transfer when valid and ready are high.
// cfg_we/cfg_wdata write life_drop, the amount a scan takes off every life.
// Push, pop and error commands give one result, registered in the cycle after
// the transfer; one command is taken every cycle the result register is free
// and no scan runs. A scan walks the queue head first, one entry per cycle:
// each entry leaves the head cell, has its life lowered, and is either
// reported as expired or written back at the tail. After the walk a done
// step registers the final result. Expired entries wait in a pending
// register so the last one can carry last.
// A stalled receiver holds the result register and freezes the scan walk.
// Reset empties the queue and sets life_drop to 1; cell contents are not
// cleared, as only occupied slots are ever read.
// ----------------------------------------------------------------------------
module aging_fifo_with_threshold_expiry_unit import afte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DROP_W-1:0] cfg_wdata,
    afte_req_if.sink          req,
    afte_rsp_if.source        rsp
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [LIFE_W-1:0] alert_reg, alert_next;
    logic [DROP_W-1:0] drop_reg;
    logic              pend_valid_reg, pend_valid_next;
    entry_t            pend_reg, pend_next;
    logic [CW-1:0]     pend_occ_reg, pend_occ_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    entry_t            rdat_reg, rdat_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              req_xfer;
    entry_t            head;
    logic [LIFE_W-1:0] lowered;
    logic              expired;
    logic              ch_shift;
    logic              ch_load;
    logic [IW-1:0]     ch_idx;
    entry_t            ch_data;

    function automatic logic [OCC_W-1:0] occ_trunc(input logic [CW-1:0] v);
        logic [CW+OCC_W-1:0] tmp;
        tmp = {{OCC_W{1'b0}}, v};
        return tmp[OCC_W-1:0];
    endfunction

    // queue storage
    afte_chain #(.DEPTH(QUEUE_DEPTH)) u_chain (
        .clk       (clk),
        .shift     (ch_shift),
        .load      (ch_load),
        .load_idx  (ch_idx),
        .load_data (ch_data),
        .head      (head)
    );

    // handshake
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign req_xfer  = req.valid && req.ready;

    // aging of the head entry during a scan
    assign lowered = (head.life > {{(LIFE_W-DROP_W){1'b0}}, drop_reg})
                   ? head.life - {{(LIFE_W-DROP_W){1'b0}}, drop_reg}
                   : '0;
    assign expired = lowered <= alert_reg;

    // command sequencing and result formation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        alert_next      = alert_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        pend_occ_next   = pend_occ_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        kind_next       = kind_reg;
        rdat_next       = rdat_reg;
        occ_next        = occ_reg;
        last_next       = last_reg;
        ch_shift        = 1'b0;
        ch_load         = 1'b0;
        ch_idx          = count_reg[IW-1:0];
        ch_data         = '{id: req.entry_id, life: req.entry_life};

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    rsp_valid_next = 1'b1;
                    rdat_next      = '0;
                    last_next      = 1'b1;
                    kind_next      = KIND_ERROR;
                    occ_next       = count_reg;
                    case (req.cmd)
                        CMD_PUSH:
                        begin
                            if (count_reg < CW'(QUEUE_DEPTH))
                            begin
                                ch_load    = 1'b1;
                                count_next = count_reg + 1'b1;
                                kind_next  = KIND_PUSHED;
                                occ_next   = count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                ch_shift   = 1'b1;
                                count_next = count_reg - 1'b1;
                                kind_next  = KIND_POPPED;
                                rdat_next  = head;
                                occ_next   = count_reg - 1'b1;
                            end
                        end
                        CMD_SCAN:
                        begin
                            rsp_valid_next = rsp_valid_reg && !rsp.ready;
                            kind_next      = kind_reg;
                            rdat_next      = rdat_reg;
                            occ_next       = occ_reg;
                            last_next      = last_reg;
                            alert_next     = req.alert_level;
                            rem_next       = count_reg;
                            state_next     = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default:
                        begin
                            kind_next = KIND_ERROR;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (out_free)
                begin
                    ch_shift = 1'b1;
                    rem_next = rem_reg - 1'b1;
                    if (expired)
                    begin
                        count_next      = count_reg - 1'b1;
                        pend_valid_next = 1'b1;
                        pend_next       = '{id: head.id, life: lowered};
                        pend_occ_next   = count_reg - 1'b1;
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            kind_next      = KIND_EXPIRED;
                            rdat_next      = pend_reg;
                            occ_next       = pend_occ_reg;
                            last_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        // survivor goes back in at the free tail slot
                        ch_load = 1'b1;
                        ch_idx  = IW'(count_reg - 1'b1);
                        ch_data = '{id: head.id, life: lowered};
                    end
                    if (rem_reg == CW'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        kind_next = KIND_EXPIRED;
                        rdat_next = pend_reg;
                        occ_next  = pend_occ_reg;
                    end
                    else
                    begin
                        kind_next = KIND_NONE;
                        rdat_next = '0;
                        occ_next  = count_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            drop_reg       <= DROP_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                drop_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        alert_reg    <= alert_next;
        pend_reg     <= pend_next;
        pend_occ_reg <= pend_occ_next;
        kind_reg     <= kind_next;
        rdat_reg     <= rdat_next;
        occ_reg      <= occ_next;
        last_reg     <= last_next;
    end

    // result channel
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.kind      = kind_reg;
    assign rsp.out_id    = rdat_reg.id;
    assign rsp.out_life  = rdat_reg.life;
    assign rsp.occupancy = occ_trunc(occ_reg);
    assign rsp.last      = last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req.cmd == CMD_PUSH) && (count_reg < CW'(QUEUE_DEPTH))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not add an entry");

    a_scan_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> count_reg <= $past(count_reg))
        else $error("scan grew the queue");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != ST_IDLE))
        else $error("held expired entry outside a scan");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rem_reg != '0) && (rem_reg <= count_reg))
        else $error("scan walk count out of range");

endmodule

>>> design/afte_cell.sv
// ----------------------------------------------------------------------------
// afte_cell: one queue slot
// Holds one entry; takes its neighbor's entry on a shift, or a new entry on
// a load, which wins over the shift.
// ----------------------------------------------------------------------------
module afte_cell import afte_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  logic   load,
    input  entry_t nb,
    input  entry_t ld,
    output entry_t q
);

    entry_t data_reg;

    // slot storage, contents undefined until first written
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= ld;
        end
        else if (shift)
        begin
            data_reg <= nb;
        end
    end

    assign q = data_reg;

endmodule

>>> design/afte_chain.sv
// ----------------------------------------------------------------------------
// afte_chain: row of queue slots
// Slot 0 is the head. A shift moves every entry one slot toward the head;
// a load writes one slot chosen by index in the same cycle.
// ----------------------------------------------------------------------------
module afte_chain import afte_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     shift,
    input  logic                     load,
    input  logic [$clog2(DEPTH)-1:0] load_idx,
    input  entry_t                   load_data,
    output entry_t                   head
);

    localparam int IW = $clog2(DEPTH);

    entry_t q [DEPTH];

    // one cell per slot, each fed by its upper neighbor; the top cell refeeds itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t nb;
        logic   ld_en;

        if (i == DEPTH - 1)
        begin : g_top
            assign nb = q[i];
        end
        else
        begin : g_mid
            assign nb = q[i+1];
        end

        assign ld_en = load && (load_idx == IW'(i));

        afte_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .load  (ld_en),
            .nb    (nb),
            .ld    (load_data),
            .q     (q[i])
        );
    end

    assign head = q[0];

endmodule

>>> bench/aging_fifo_with_threshold_expiry_unit_test.sv
// ----------------------------------------------------------------------------
// aging_fifo_with_threshold_expiry_unit_test: self-checking bench of the fifo
// Drives push, pop and scan commands over the request channel. A shadow
// queue in the bench ages and expires its entries the same way, and every
// result transfer is checked field by field against the oldest predicted
// result. Random idle gaps on both channels, a long receiver hold-off, a
// sender pause and several life_drop settings are applied along the way.
// ----------------------------------------------------------------------------
module aging_fifo_with_threshold_expiry_unit_test import afte_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH            = 16;
    localparam int CLK_HALF         = 6;
    localparam int PHASE_ITEMS      = 68;
    localparam int SETTLE_CYCLES    = DEPTH + 8;
    localparam int DRAIN_LIMIT      = 200000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam longint TIMEOUT_NS   = 64'd24_000_000;

    // command code that the block treats as an error
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   entry_id;
        logic [LIFE_W-1:0] entry_life;
        logic [LIFE_W-1:0] alert_level;
    } fifo_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } fifo_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [DROP_W-1:0] cfg_wdata;

    afte_req_if req_ch ();
    afte_rsp_if rsp_ch ();

    aging_fifo_with_threshold_expiry_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow copy of the queue and its register
    logic [ID_W-1:0]   shadow_id [DEPTH];
    logic [LIFE_W-1:0] shadow_life [DEPTH];
    int                shadow_count;
    logic [DROP_W-1:0] drop_now;

    fifo_cmd_t    queued_cmds[$];
    fifo_result_t awaited_results[$];

    int fault_count;
    int send_gap;
    int take_gap;
    bit idle_on;
    bit sender_paused;
    bit hold_requested;
    bit sink_blocked;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic fifo_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                           logic [LIFE_W-1:0] life,
                                           logic [LIFE_W-1:0] alert);
        fifo_cmd_t c;
        c.cmd         = cmd;
        c.entry_id    = id;
        c.entry_life  = life;
        c.alert_level = alert;
        return c;
    endfunction

    // random command mix, weighted so the queue fills and scans expire entries
    function automatic fifo_cmd_t random_cmd();
        fifo_cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            c.cmd = CMD_PUSH;
        else if (r < 67)
            c.cmd = CMD_POP;
        else if (r < 95)
            c.cmd = CMD_SCAN;
        else
            c.cmd = CMD_UNUSED;
        c.entry_id = ID_W'($urandom_range(0, 16'hffff));
        if ($urandom_range(0, 1) == 1)
            c.entry_life = LIFE_W'($urandom_range(0, 160));
        else
            c.entry_life = LIFE_W'($urandom_range(0, 1023));
        r = $urandom_range(0, 9);
        if (r < 4)
            c.alert_level = LIFE_W'($urandom_range(0, 120));
        else if (r < 8)
            c.alert_level = LIFE_W'($urandom_range(0, 1023));
        else if (r == 8)
            c.alert_level = '0;
        else
            c.alert_level = '1;
        return c;
    endfunction

    // apply one accepted command to the shadow queue and queue up its results
    task automatic serve_command(input fifo_cmd_t c);
        fifo_result_t batch[$];
        fifo_result_t r;
        int n;
        int w;
        int l;
        r.kind      = KIND_ERROR;
        r.id        = '0;
        r.life      = '0;
        r.occupancy = OCC_W'(shadow_count);
        r.last      = 1'b1;
        case (c.cmd)
            CMD_PUSH:
            begin
                if (shadow_count < DEPTH)
                begin
                    shadow_id[shadow_count]   = c.entry_id;
                    shadow_life[shadow_count] = c.entry_life;
                    shadow_count++;
                    r.kind      = KIND_PUSHED;
                    r.occupancy = OCC_W'(shadow_count);
                end
                batch.push_back(r);
            end
            CMD_POP:
            begin
                if (shadow_count > 0)
                begin
                    r.kind = KIND_POPPED;
                    r.id   = shadow_id[0];
                    r.life = shadow_life[0];
                    for (int i = 1; i < shadow_count; i++)
                    begin
                        shadow_id[i-1]   = shadow_id[i];
                        shadow_life[i-1] = shadow_life[i];
                    end
                    shadow_count--;
                    r.occupancy = OCC_W'(shadow_count);
                end
                batch.push_back(r);
            end
            CMD_SCAN:
            begin
                n = shadow_count;
                w = 0;
                for (int i = 0; i < n; i++)
                begin
                    // age with saturation at zero
                    l = int'(shadow_life[i]);
                    if (l > int'(drop_now))
                        l = l - int'(drop_now);
                    else
                        l = 0;
                    if (l <= int'(c.alert_level))
                    begin
                        r.kind      = KIND_EXPIRED;
                        r.id        = shadow_id[i];
                        r.life      = LIFE_W'(l);
                        r.occupancy = OCC_W'(n - batch.size() - 1);
                        r.last      = 1'b0;
                        batch.push_back(r);
                    end
                    else
                    begin
                        shadow_id[w]   = shadow_id[i];
                        shadow_life[w] = LIFE_W'(l);
                        w++;
                    end
                end
                shadow_count = w;
                if (batch.size() == 0)
                begin
                    r.kind      = KIND_NONE;
                    r.occupancy = OCC_W'(shadow_count);
                    batch.push_back(r);
                end
                else
                    batch[batch.size()-1].last = 1'b1;
            end
            default:
                batch.push_back(r);
        endcase
        foreach (batch[i])
            awaited_results.push_back(batch[i]);
    endtask

    // request driver
    always @(posedge clk)
    begin
        fifo_cmd_t taken;
        fifo_cmd_t next_cmd;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.cmd         = req_ch.cmd;
                taken.entry_id    = req_ch.entry_id;
                taken.entry_life  = req_ch.entry_life;
                taken.alert_level = req_ch.alert_level;
                serve_command(taken);
                send_gap = idle_on ? idle_span() : 0;
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // hold the offered item until the transfer
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (queued_cmds.size() > 0 && !sender_paused)
            begin
                next_cmd = queued_cmds.pop_front();
                req_ch.cmd         <= next_cmd.cmd;
                req_ch.entry_id    <= next_cmd.entry_id;
                req_ch.entry_life  <= next_cmd.entry_life;
                req_ch.alert_level <= next_cmd.alert_level;
                req_ch.valid       <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        fifo_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d id %0h life %0d occupancy %0d last %0d",
                           rsp_ch.kind, rsp_ch.out_id, rsp_ch.out_life, rsp_ch.occupancy,
                           rsp_ch.last);
                    fault_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
                        fault_count++;
                    end
                    if (rsp_ch.out_id !== want.id)
                    begin
                        $error("out_id: expected %0h, actual %0h", want.id, rsp_ch.out_id);
                        fault_count++;
                    end
                    if (rsp_ch.out_life !== want.life)
                    begin
                        $error("out_life: expected %0d, actual %0d", want.life, rsp_ch.out_life);
                        fault_count++;
                    end
                    if (rsp_ch.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, actual %0d", want.occupancy,
                               rsp_ch.occupancy);
                        fault_count++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                        fault_count++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (sink_blocked)
                rsp_ch.ready <= 1'b0;
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    take_gap = idle_span();
            end
        end
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        sink_blocked = 1'b0;
        wait (hold_requested);
        @(posedge clk);
        sink_blocked <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_blocked <= 1'b0;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // wait until every queued command went out and every result came back
    task automatic settle_out();
        int waited;
        waited = 0;
        while (queued_cmds.size() > 0 || req_ch.valid || awaited_results.size() > 0)
        begin
            @(negedge clk);
            waited++;
            if (waited > DRAIN_LIMIT)
            begin
                $error("results still outstanding: %0d", awaited_results.size());
                fault_count++;
                break;
            end
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_drop(input logic [DROP_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        drop_now   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [DROP_W-1:0] drop_plan [6];
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_PUSH;
        req_ch.entry_id    = '0;
        req_ch.entry_life  = '0;
        req_ch.alert_level = '0;
        rsp_ch.ready       = 1'b0;
        shadow_count       = 0;
        drop_now           = 6'd1;
        fault_count        = 0;
        send_gap           = 0;
        take_gap           = 0;
        idle_on            = 1'b1;
        sender_paused      = 1'b0;
        hold_requested     = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // errors and a scan on the empty queue, with the reset life_drop
        queued_cmds.push_back(make_cmd(CMD_POP, '1, '1, '1));
        queued_cmds.push_back(make_cmd(CMD_UNUSED, '0, '0, '0));
        queued_cmds.push_back(make_cmd(CMD_SCAN, 16'h1234, 10'd5, '1));
        // fill to the top: largest entry at the head, zero and one lives behind it
        queued_cmds.push_back(make_cmd(CMD_PUSH, '1, '1, '0));
        queued_cmds.push_back(make_cmd(CMD_PUSH, '0, '0, '0));
        queued_cmds.push_back(make_cmd(CMD_PUSH, ID_W'($urandom_range(0, 16'hffff)),
                                       10'd1, '0));
        for (int i = 3; i < DEPTH; i++)
            queued_cmds.push_back(make_cmd(CMD_PUSH, ID_W'($urandom_range(0, 16'hffff)),
                                           LIFE_W'($urandom_range(2, 1023)), '0));
        // push to a full queue, unused command with entries present
        queued_cmds.push_back(make_cmd(CMD_PUSH, 16'haaaa, '1, '0));
        queued_cmds.push_back(make_cmd(CMD_UNUSED, '1, '1, '1));
        // lowest alert: only lives that saturate at zero expire
        queued_cmds.push_back(make_cmd(CMD_SCAN, '0, '0, '0));
        queued_cmds.push_back(make_cmd(CMD_POP, '0, '0, '0));
        // highest alert: everything left expires in one scan
        queued_cmds.push_back(make_cmd(CMD_SCAN, '0, '0, '1));
        settle_out();

        drop_plan[0] = '0;
        drop_plan[1] = '1;
        drop_plan[2] = DROP_W'($urandom_range(2, 62));
        drop_plan[3] = 6'd1;
        drop_plan[4] = DROP_W'($urandom_range(0, 63));
        drop_plan[5] = 6'd32;

        for (int p = 0; p < 6; p++)
        begin
            write_drop(drop_plan[p]);
            @(negedge clk);
            // one phase with no idling on either side
            idle_on = (p != 3);
            if (p == 1)
                hold_requested = 1'b1;
            if (p == 2)
            begin
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                    queued_cmds.push_back(random_cmd());
                while (queued_cmds.size() > 0)
                    @(negedge clk);
                // sender pauses until every result is back
                sender_paused = 1'b1;
                while (req_ch.valid || awaited_results.size() > 0)
                    @(negedge clk);
                sender_paused = 1'b0;
                for (int i = 0; i < PHASE_ITEMS - PHASE_ITEMS / 2; i++)
                    queued_cmds.push_back(random_cmd());
            end
            else
            begin
                for (int i = 0; i < PHASE_ITEMS; i++)
                    queued_cmds.push_back(random_cmd());
            end
            settle_out();
        end

        if (awaited_results.size() != 0)
        begin
            $error("results never received: %0d", awaited_results.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
